// ===== rtl/skhf_pkg.sv =====
package skhf_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int QW = DW + FB;
  localparam int MCW = $clog2(DW);
  localparam int DCW = $clog2(QW);

  localparam logic [DW-1:0] DEG360 = DW'(360 << FB);
  localparam logic [DW-1:0] DEG180 = DW'(180 << FB);

  localparam logic [2:0] CFG_SOURCE = 3'd0;
  localparam logic [2:0] CFG_W_ENC = 3'd1;
  localparam logic [2:0] CFG_W_GYR = 3'd2;
  localparam logic [2:0] CFG_N_ENC = 3'd3;
  localparam logic [2:0] CFG_N_GYR = 3'd4;
  localparam logic [2:0] CFG_Q = 3'd5;
  localparam logic [2:0] CFG_INIT_VAR = 3'd6;

  localparam logic [1:0] SRC_GYRO = 2'd0;
  localparam logic [1:0] SRC_ENC = 2'd1;
  localparam logic [1:0] SRC_FUSED = 2'd2;

  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_CHK, OP_WRAP, OP_END
  } uop_t;

  typedef enum logic [3:0] {
    S_X, S_P1, S_W1, S_R1, S_M1, S_W2, S_R2, S_M2,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_XN, S_PN
  } slot_t;

  typedef struct packed {
    uop_t  op;
    slot_t a;
    slot_t b;
    slot_t d;
  } uinst_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_FETCH, ST_EXEC, ST_WAIT, ST_DONE
  } state_t;

  function automatic uinst_t ui(uop_t o, slot_t a, slot_t b, slot_t d);
    uinst_t u;
    u.op = o;
    u.a = a;
    u.b = b;
    u.d = d;
    return u;
  endfunction

  // saturate an unsigned magnitude with sign to a signed word
  function automatic logic [DW-1:0] sat_mag(input logic [2*DW-1:0] m, input logic neg);
    logic [2*DW-1:0] lim;
    logic [DW-1:0] r;
    lim = {{DW{1'b0}}, 1'b1, {(DW-1){1'b0}}};
    if (neg) begin
      if (m >= lim) r = {1'b1, {(DW-1){1'b0}}};
      else r = -m[DW-1:0];
    end else begin
      if (m >= lim) r = {1'b0, {(DW-1){1'b1}}};
      else r = m[DW-1:0];
    end
    return r;
  endfunction

  function automatic uinst_t ucode(input logic [1:0] mode, input logic [4:0] pc);
    uinst_t u;
    u = ui(OP_END, S_XN, S_PN, S_XN);
    if (mode == SRC_FUSED) begin
      case (pc)
        5'd0: u = ui(OP_MUL, S_W1, S_W1, S_T0);
        5'd1: u = ui(OP_MUL, S_P1, S_T0, S_T0);
        5'd2: u = ui(OP_MUL, S_T0, S_R2, S_T0);
        5'd3: u = ui(OP_MUL, S_W2, S_W2, S_T1);
        5'd4: u = ui(OP_MUL, S_P1, S_T1, S_T1);
        5'd5: u = ui(OP_MUL, S_T1, S_R1, S_T1);
        5'd6: u = ui(OP_ADD, S_T0, S_T1, S_T0);
        5'd7: u = ui(OP_MUL, S_R1, S_R2, S_T1);
        5'd8: u = ui(OP_ADD, S_T0, S_T1, S_T0);
        5'd9: u = ui(OP_CHK, S_T0, S_T0, S_T0);
        5'd10: u = ui(OP_MUL, S_P1, S_W1, S_T1);
        5'd11: u = ui(OP_MUL, S_T1, S_R2, S_T1);
        5'd12: u = ui(OP_DIV, S_T1, S_T0, S_T1);
        5'd13: u = ui(OP_MUL, S_P1, S_W2, S_T2);
        5'd14: u = ui(OP_MUL, S_T2, S_R1, S_T2);
        5'd15: u = ui(OP_DIV, S_T2, S_T0, S_T2);
        5'd16: u = ui(OP_MUL, S_W1, S_X, S_T3);
        5'd17: u = ui(OP_SUB, S_M1, S_T3, S_T3);
        5'd18: u = ui(OP_MUL, S_W2, S_X, S_T4);
        5'd19: u = ui(OP_SUB, S_M2, S_T4, S_T4);
        5'd20: u = ui(OP_MUL, S_T1, S_T3, S_T3);
        5'd21: u = ui(OP_ADD, S_X, S_T3, S_T3);
        5'd22: u = ui(OP_MUL, S_T2, S_T4, S_T4);
        5'd23: u = ui(OP_ADD, S_T3, S_T4, S_XN);
        5'd24: u = ui(OP_WRAP, S_XN, S_XN, S_XN);
        5'd25: u = ui(OP_MUL, S_T1, S_W1, S_T1);
        5'd26: u = ui(OP_MUL, S_T2, S_W2, S_T2);
        5'd27: u = ui(OP_ADD, S_T1, S_T2, S_T1);
        5'd28: u = ui(OP_MUL, S_P1, S_T1, S_T1);
        5'd29: u = ui(OP_SUB, S_P1, S_T1, S_PN);
        default: u = ui(OP_END, S_XN, S_PN, S_XN);
      endcase
    end else if (mode == SRC_GYRO || mode == SRC_ENC) begin
      case (pc)
        5'd0: u = ui(OP_MUL, S_W1, S_P1, S_T0);
        5'd1: u = ui(OP_MUL, S_T0, S_W1, S_T1);
        5'd2: u = ui(OP_ADD, S_T1, S_R1, S_T1);
        5'd3: u = ui(OP_CHK, S_T1, S_T1, S_T1);
        5'd4: u = ui(OP_DIV, S_T0, S_T1, S_T2);
        5'd5: u = ui(OP_MUL, S_W1, S_X, S_T3);
        5'd6: u = ui(OP_SUB, S_M1, S_T3, S_T3);
        5'd7: u = ui(OP_MUL, S_T2, S_T3, S_T4);
        5'd8: u = ui(OP_ADD, S_X, S_T4, S_XN);
        5'd9: u = ui(OP_MUL, S_T2, S_W1, S_T4);
        5'd10: u = ui(OP_MUL, S_T4, S_P1, S_T4);
        5'd11: u = ui(OP_SUB, S_P1, S_T4, S_PN);
        default: u = ui(OP_END, S_XN, S_PN, S_XN);
      endcase
    end else begin
      // unused selector: estimate kept, predicted variance stored
      u = ui(OP_END, S_X, S_P1, S_XN);
    end
    return u;
  endfunction

endpackage

// ===== rtl/skhf_mul.sv =====
module skhf_mul
  import skhf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  output logic                 done,
  output logic [DW-1:0]        y
);

  logic busy;
  logic fin;
  logic neg;
  logic [MCW-1:0] cnt;
  logic [DW-1:0] ma;
  logic [DW-1:0] hi;
  logic [DW-1:0] lo;
  logic [DW:0] psum;
  logic [2*DW-1:0] rnd;

  // one multiplier bit per cycle
  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, ma} : {(DW+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= a[DW-1] ^ b[DW-1];
        ma <= a[DW-1] ? -a : a;
        lo <= b[DW-1] ? -b : b;
        hi <= '0;
      end else if (busy) begin
        hi <= psum[DW:1];
        lo <= {psum[0], lo[DW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == MCW'(DW - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // round half away from zero on the magnitude
  assign rnd = {hi, lo} + (2*DW)'(1 << (FB - 1));
  assign y = sat_mag(rnd >> FB, neg);
  assign done = fin;

endmodule

// ===== rtl/skhf_div.sv =====
module skhf_div
  import skhf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] n,
  input  logic signed [DW-1:0] d,
  output logic                 done,
  output logic [DW-1:0]        y
);

  logic busy;
  logic fin;
  logic neg;
  logic [DCW-1:0] cnt;
  logic [DW-1:0] ud;
  logic [DW-1:0] rem;
  logic [QW-1:0] qd;
  logic [DW:0] trial;
  logic take;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, qd[QW-1]};
  assign take = trial >= {1'b0, ud};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= n[DW-1] ^ d[DW-1];
        ud <= d[DW-1] ? -d : d;
        qd <= {(n[DW-1] ? -n : n), {FB{1'b0}}};
        rem <= '0;
      end else if (busy) begin
        if (take) rem <= DW'(trial - {1'b0, ud});
        else rem <= trial[DW-1:0];
        qd <= {qd[QW-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == DCW'(QW - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  assign y = sat_mag((2*DW)'(qd), neg);
  assign done = fin;

endmodule

// ===== rtl/scalar_kalman_heading_fusion.sv =====
// scalar kalman heading filter, one estimate and one variance
// in channel: in_valid/in_ready with encoder_value, gyro_value, unwrap_enable
// out channel: out_valid/out_ready with estimate and variance, one result per
//   input transaction, held in an output register until taken
// cfg channel: cfg_valid/cfg_ready, cfg_index 0..6 selects the register,
//   cfg_data carries the value; always ready, write only while idle;
//   writing initial_variance also reloads the stored variance
// each update runs a short microprogram over a 16-entry scratch memory
// using a bit-serial multiplier and a bit-serial divider; one item is
// processed at a time
// a zero denominator or determinant ends the update early and repeats the
// stored state
// reset: estimate 0, variance and registers to their reset values
// a stalled receiver holds the next result back; the next input is taken
// once the current one has been delivered to the output register
module scalar_kalman_heading_fusion
  import skhf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] encoder_value,
  input  logic signed [DW-1:0] gyro_value,
  input  logic                 unwrap_enable,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] estimate,
  output logic [DW-2:0]        variance,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  state_t state, state_next;

  logic [1:0] src_sel;
  logic [20:0] w_enc, w_gyr;
  logic [30:0] n_enc, n_gyr, q_proc;

  logic signed [DW-1:0] x_st;
  logic [DW-2:0] p_st;

  logic signed [DW-1:0] e_q, g_q;
  logic unw_q;

  logic [4:0] pc;
  logic [2:0] lcnt;
  uinst_t uc;

  logic [DW-1:0] rf [16];
  logic [DW-1:0] ra, rb;
  logic wr_en;
  slot_t wr_addr;
  logic [DW-1:0] wr_data;

  logic mul_start, mul_done, div_start, div_done;
  logic [DW-1:0] mul_y, div_y;

  logic signed [DW-1:0] e_u, g_u;
  logic [DW-1:0] p1_sum, load_val, alu_y;
  logic keep, store;

  assign uc = ucode(src_sel, pc);
  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE);

  function automatic logic [DW-1:0] sat_sum(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                            input logic sub);
    logic [DW:0] s;
    s = sub ? {a[DW-1], a} - {b[DW-1], b} : {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    return s[DW-1:0];
  endfunction

  // unwrap around the estimate in fused mode
  always_comb begin
    e_u = e_q;
    g_u = g_q;
    if (unw_q && src_sel == SRC_FUSED) begin
      if (x_st < $signed(DEG180)) begin
        if (e_q > $signed(DEG180)) e_u = e_q - $signed(DEG360);
        if (g_q > $signed(DEG180)) g_u = g_q - $signed(DEG360);
      end else begin
        if (e_q < $signed(DEG180)) e_u = e_q + $signed(DEG360);
        if (g_q < $signed(DEG180)) g_u = g_q + $signed(DEG360);
      end
    end
  end

  assign p1_sum = DW'({1'b0, p_st}) + DW'({1'b0, q_proc});

  always_comb begin
    case (lcnt)
      3'd0: load_val = x_st;
      3'd1: load_val = p1_sum[DW-1] ? {1'b0, {(DW-1){1'b1}}} : p1_sum;
      3'd2: load_val = DW'(src_sel == SRC_GYRO ? w_gyr : w_enc);
      3'd3: load_val = DW'(src_sel == SRC_GYRO ? n_gyr : n_enc);
      3'd4: load_val = src_sel == SRC_GYRO ? g_u : e_u;
      3'd5: load_val = DW'(w_gyr);
      3'd6: load_val = DW'(n_gyr);
      3'd7: load_val = g_u;
      default: load_val = '0;
    endcase
  end

  always_comb begin
    case (uc.op)
      OP_ADD: alu_y = sat_sum(ra, rb, 1'b0);
      OP_SUB: alu_y = sat_sum(ra, rb, 1'b1);
      OP_WRAP: begin
        if ($signed(ra) >= $signed(DEG360)) alu_y = ra - DEG360;
        else if ($signed(ra) < 0) alu_y = ra + DEG360;
        else alu_y = ra;
      end
      default: alu_y = ra;
    endcase
  end

  always_comb begin
    state_next = state;
    wr_en = 1'b0;
    wr_addr = uc.d;
    wr_data = alu_y;
    mul_start = 1'b0;
    div_start = 1'b0;
    keep = 1'b0;
    store = 1'b0;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        wr_en = 1'b1;
        wr_addr = slot_t'({1'b0, lcnt});
        wr_data = load_val;
        if (lcnt == 3'd7) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_EXEC;
      ST_EXEC: begin
        case (uc.op)
          OP_MUL: begin
            mul_start = 1'b1;
            state_next = ST_WAIT;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_next = ST_WAIT;
          end
          OP_CHK: begin
            if (ra == '0) begin
              keep = 1'b1;
              state_next = ST_DONE;
            end else begin
              state_next = ST_FETCH;
            end
          end
          OP_END: begin
            store = 1'b1;
            state_next = ST_DONE;
          end
          default: begin
            wr_en = 1'b1;
            state_next = ST_FETCH;
          end
        endcase
      end
      ST_WAIT: begin
        if (uc.op == OP_DIV) begin
          wr_data = div_y;
          if (div_done) begin
            wr_en = 1'b1;
            state_next = ST_FETCH;
          end
        end else begin
          wr_data = mul_y;
          if (mul_done) begin
            wr_en = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) rf[wr_addr] <= wr_data;
    ra <= rf[uc.a];
    rb <= rf[uc.b];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      e_q <= encoder_value;
      g_q <= gyro_value;
      unw_q <= unwrap_enable;
    end
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      estimate <= x_st;
      variance <= p_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_sel <= SRC_FUSED;
      w_enc <= 21'd65536;
      w_gyr <= 21'd65536;
      n_enc <= 31'd65536;
      n_gyr <= 31'd65536;
      q_proc <= 31'd66;
      x_st <= '0;
      p_st <= 31'd66;
      out_valid <= 1'b0;
      pc <= '0;
      lcnt <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SOURCE: src_sel <= cfg_data[1:0];
          CFG_W_ENC: w_enc <= cfg_data[20:0];
          CFG_W_GYR: w_gyr <= cfg_data[20:0];
          CFG_N_ENC: n_enc <= cfg_data[30:0];
          CFG_N_GYR: n_gyr <= cfg_data[30:0];
          CFG_Q: q_proc <= cfg_data[30:0];
          CFG_INIT_VAR: p_st <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (state == ST_IDLE) begin
        lcnt <= '0;
        pc <= '0;
      end
      if (state == ST_LOAD) lcnt <= lcnt + 1'b1;
      if (state_next == ST_FETCH && state != ST_LOAD) pc <= pc + 1'b1;
      if (store && !keep) begin
        x_st <= $signed(ra);
        // variance clamps to the non-negative range
        p_st <= rb[DW-1] ? '0 : rb[DW-2:0];
      end
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  skhf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     ($signed(ra)),
    .b     ($signed(rb)),
    .done  (mul_done),
    .y     (mul_y)
  );

  skhf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     ($signed(ra)),
    .d     ($signed(rb)),
    .done  (div_done),
    .y     (div_y)
  );

`ifndef NO_ASSERTIONS
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done)) else $error("multiplier and divider finished together");

  a_wait_op: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> (uc.op == OP_MUL || uc.op == OP_DIV))
    else $error("waiting on a unit for an alu op");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("result not presented");
`endif

endmodule

// ===== verif/scalar_kalman_heading_fusion_checker.sv =====
`timescale 1ns / 1ps

module scalar_kalman_heading_fusion_checker
  import skhf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [DW-1:0] encoder_value,
  input  logic signed [DW-1:0] gyro_value,
  input  logic                 unwrap_enable,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [DW-1:0] estimate,
  input  logic [DW-2:0]        variance,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count
);

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] est;
    logic [30:0]        var_q;
  } heading_t;

  heading_t heading_q[$];
  int       mismatches;

  logic [1:0] mode;
  longint     w_enc, w_gyr, n_enc, n_gyr, q_noise, p_init;
  longint     x_state, p_state;

  assign fail_count = mismatches + heading_q.size();

  function automatic longint clip(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint signed_limit(input longint m, input bit neg);
    if (m > WORD_MAX + 1) m = WORD_MAX + 1;
    if (neg) return -m;
    return (m > WORD_MAX) ? WORD_MAX : m;
  endfunction

  // rounded half away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    longint ma, mb;
    bit neg;
    a = clip(a);
    b = clip(b);
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    return signed_limit((ma * mb + 64'sd32768) >>> FB, neg);
  endfunction

  function automatic longint fx_div(input longint n, input longint d);
    longint mn, md;
    bit neg;
    n = clip(n);
    d = clip(d);
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    return signed_limit((mn <<< FB) / md, neg);
  endfunction

  function automatic void kalman_update(input longint e, input longint g, input bit unwrap);
    longint deg360, deg180, x, p1, xn, pn, w, r, m, s, den, k, det, k0, k1;
    bit hold;
    deg360 = longint'(DEG360);
    deg180 = longint'(DEG180);
    x = x_state;
    p1 = p_state + q_noise;
    if (p1 > WORD_MAX) p1 = WORD_MAX;
    xn = x;
    pn = p1;
    hold = 0;
    if (mode == SRC_GYRO || mode == SRC_ENC) begin
      w = (mode == SRC_GYRO) ? w_gyr : w_enc;
      r = (mode == SRC_GYRO) ? n_gyr : n_enc;
      m = (mode == SRC_GYRO) ? g : e;
      s = fx_mul(w, p1);
      den = clip(fx_mul(s, w) + r);
      if (den == 0) begin
        hold = 1;
      end else begin
        k = fx_div(s, den);
        xn = x + fx_mul(k, clip(m - fx_mul(w, x)));
        pn = p1 - fx_mul(fx_mul(k, w), p1);
      end
    end else if (mode == SRC_FUSED) begin
      if (unwrap) begin
        if (x < deg180) begin
          if (e > deg180) e -= deg360;
          if (g > deg180) g -= deg360;
        end else begin
          if (e < deg180) e += deg360;
          if (g < deg180) g += deg360;
        end
      end
      det = clip(fx_mul(fx_mul(p1, fx_mul(w_enc, w_enc)), n_gyr) +
                 fx_mul(fx_mul(p1, fx_mul(w_gyr, w_gyr)), n_enc));
      det = clip(det + fx_mul(n_enc, n_gyr));
      if (det == 0) begin
        hold = 1;
      end else begin
        k0 = fx_div(fx_mul(fx_mul(p1, w_enc), n_gyr), det);
        k1 = fx_div(fx_mul(fx_mul(p1, w_gyr), n_enc), det);
        xn = clip(x + fx_mul(k0, clip(e - fx_mul(w_enc, x))));
        xn = clip(xn + fx_mul(k1, clip(g - fx_mul(w_gyr, x))));
        pn = p1 - fx_mul(p1, clip(fx_mul(k0, w_enc) + fx_mul(k1, w_gyr)));
        if (xn >= deg360) xn -= deg360;
        else if (xn < 0) xn += deg360;
      end
    end
    if (!hold) begin
      x_state = clip(xn);
      p_state = (pn > WORD_MAX) ? WORD_MAX : ((pn < 0) ? 0 : pn);
    end
  endfunction

  always @(posedge clk) begin
    heading_t want;
    if (rst) begin
      mode = SRC_FUSED;
      w_enc = 65536;
      w_gyr = 65536;
      n_enc = 65536;
      n_gyr = 65536;
      q_noise = 66;
      p_init = 66;
      x_state = 0;
      p_state = 66;
      heading_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SOURCE:   mode = cfg_data[1:0];
          CFG_W_ENC:    w_enc = longint'(cfg_data[20:0]);
          CFG_W_GYR:    w_gyr = longint'(cfg_data[20:0]);
          CFG_N_ENC:    n_enc = longint'(cfg_data[30:0]);
          CFG_N_GYR:    n_gyr = longint'(cfg_data[30:0]);
          CFG_Q:        q_noise = longint'(cfg_data[30:0]);
          CFG_INIT_VAR: begin
            p_init = longint'(cfg_data[30:0]);
            p_state = p_init;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        kalman_update(longint'(encoder_value), longint'(gyro_value), unwrap_enable);
        want.est = x_state[31:0];
        want.var_q = p_state[30:0];
        heading_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (heading_q.size() == 0) begin
          $error("result transaction with nothing expected: estimate %0d variance %0d",
                 estimate, variance);
          mismatches++;
        end else begin
          want = heading_q.pop_front();
          if (estimate !== want.est) begin
            $error("estimate: expected %0d, actual %0d", want.est, estimate);
            mismatches++;
          end
          if (variance !== want.var_q) begin
            $error("variance: expected %0d, actual %0d", want.var_q, variance);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/scalar_kalman_heading_fusion_tb.sv =====
`timescale 1ns / 1ps

module scalar_kalman_heading_fusion_tb;
  import skhf_pkg::*;

  localparam logic [2:0] CFG_SPARE = 3'd7;
  localparam logic [1:0] SRC_IDLE = 2'd3;
  localparam int STALL_LIMIT = 20000;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic signed [DW-1:0] encoder_value = '0;
  logic signed [DW-1:0] gyro_value = '0;
  logic                 unwrap_enable = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic signed [DW-1:0] estimate;
  logic [DW-2:0]        variance;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  int                   fail_count;

  int  sent = 0;
  int  taken = 0;
  int  quiet = 0;
  int  stall_left = 0;
  bit  calm = 0;

  always #6 clk = ~clk;

  scalar_kalman_heading_fusion DUT (.*);

  scalar_kalman_heading_fusion_checker checker_i (.*);

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) taken <= taken + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays up between back-to-back transactions; drain() drops it
  task automatic send_reading(input logic [31:0] e, input logic [31:0] g, input bit uw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    encoder_value <= e;
    gyro_value <= g;
    unwrap_enable <= uw;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (taken != sent) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_reading();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h0168_0000);
      5:       return -$urandom_range(0, 32'h00B4_0000);
      6, 7:    return $urandom;
      8:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return DEG180 + $urandom_range(0, 4) - 2;
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32'h0010_0000;
      2:       return 32'h0001_0000;
      3:       return {11'($urandom_range(0, 2047)), 21'($urandom)};
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[8];
    int n;
    logic [1:0] src;
    edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 0, DEG180, DEG360, 32'hFFFF_FFFF,
                  DEG180 + 1, DEG360 - 1};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: fused heading with and without unwrap, then gyro, encoder and unused selector modes
    foreach (edge_vals[i]) send_reading(edge_vals[i], edge_vals[7 - i], i[0]);
    send_reading(DEG180 - 1, DEG180 + 1, 1);
    send_reading(DEG360 + 5, 32'h0001_0000, 1);
    drain();
    write_reg(CFG_SOURCE, 32'(SRC_GYRO));
    send_reading(0, 32'h7FFF_FFFF, 0);
    send_reading(0, 32'h8000_0000, 1);
    drain();
    write_reg(CFG_SOURCE, 32'(SRC_ENC));
    send_reading(32'h7FFF_FFFF, 0, 0);
    send_reading(32'h8000_0000, 0, 0);
    drain();
    write_reg(CFG_SOURCE, 32'(SRC_IDLE));
    write_reg(CFG_Q, 32'h7FFF_FFFF);
    send_reading(1, 2, 1);
    send_reading(3, 4, 0);
    drain();
    // zero denominator and zero determinant
    write_reg(CFG_N_ENC, 0);
    write_reg(CFG_N_GYR, 0);
    write_reg(CFG_W_GYR, 0);
    write_reg(CFG_INIT_VAR, 32'h0000_1000);
    write_reg(CFG_SOURCE, 32'(SRC_GYRO));
    send_reading(5, 6, 0);
    drain();
    write_reg(CFG_SOURCE, 32'(SRC_FUSED));
    send_reading(DEG180, DEG180, 1);
    drain();
    write_reg(CFG_SPARE, $urandom);

    for (int ph = 0; ph < 14; ph++) begin
      calm = (ph % 4 == 3);
      src = (ph < 4) ? ph[1:0] : ((ph % 7 == 6) ? SRC_IDLE : 2'($urandom_range(0, 2)));
      write_reg(CFG_SOURCE, 32'(src));
      write_reg(CFG_W_ENC, pick_weight());
      write_reg(CFG_W_GYR, pick_weight());
      write_reg(CFG_N_ENC, pick_noise());
      write_reg(CFG_N_GYR, pick_noise());
      write_reg(CFG_Q, $urandom_range(0, 1) ? $urandom_range(0, 32'h0000_1000) : pick_noise());
      write_reg(CFG_INIT_VAR, pick_noise());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom);
      n = (src == SRC_FUSED) ? 40 : 95;
      for (int i = 0; i < n; i++)
        send_reading(pick_reading(), pick_reading(), 1'($urandom_range(0, 1)));
      drain();
    end

    calm = 1;
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
